// ===== hw/rtl/bhsl_pkg.sv =====
// Package for the bit handshake serial link: link phase codes, configuration
// register indexes and the structs passed between the link modules.
// No dependencies.
package bhsl_pkg;

    // Link phases, as reported on the link_state output.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_READ  = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_WEND  = 3'd3;
    localparam logic [2:0] PH_PULSE = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAY_INITIATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 3'd4;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned PULSE_W = 8;
    localparam int unsigned COUNT_OUT_W = 5;

    typedef struct packed {
        logic               may_initiate;
        logic [TICK_W-1:0]  frame_timeout;
        logic [TICK_W-1:0]  read_delay;
        logic [TICK_W-1:0]  write_delay;
        logic [PULSE_W-1:0] pulse_ticks;
    } t_cfg;

    // Transmit queue status as seen after this tick's push.
    typedef struct packed {
        logic has_data;
        logic head_bit;
        logic dropped;
    } t_fifo_stat;

    // Per-tick results produced by the link controller.
    typedef struct packed {
        logic       line_out;
        logic       rx_valid;
        logic       rx_bit;
        logic [2:0] link_state;
        logic       frame_ended;
        logic       initiator;
    } t_link_res;

endpackage

// ===== hw/rtl/bit_handshake_serial_link.sv =====
// Top level of the bit handshake serial link: input register, configuration
// registers, result register. Depends on bhsl_pkg, bhsl_ctrl, bhsl_tx_fifo.
//
// Usage. Each transaction on the input channel (i_in_valid / o_in_stall) is
// one timing tick of the line: the sampled input pin and an optional bit to
// queue for sending. For every input transaction exactly one result
// transaction appears on the output channel (o_out_valid / i_out_stall),
// carrying the driven line level, any bit received this tick, the queue fill,
// a drop flag for a push into a full queue, the link phase, the frame end
// flag and whether this side started the frame.
// From input acceptance to the result being valid, the tick sits in the
// input register, and a single pass through the link controller and queue
// logic loads the result register once that register can take it.
// Throughput is one transaction per cycle without output stalls; the only
// loop is the controller state update, which completes in that single pass.
// When the receiver stalls, the held result stays put, one more transaction
// is absorbed by the input register, and only then is o_in_stall raised.
// A synchronous low i_rst_n empties the queue, returns the link to idle with
// the line driven low, and loads the configuration defaults (initiation
// allowed, frame timeout 1000, read and write delays 50, pulse length 10).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
// no transactions are in flight; unknown indexes are ignored.
module bit_handshake_serial_link #(
    parameter int TX_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_pin_level,
    input  logic                              i_tx_valid,
    input  logic                              i_tx_bit,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_line_out,
    output logic                              o_rx_valid,
    output logic                              o_rx_bit,
    output logic [bhsl_pkg::COUNT_OUT_W-1:0]  o_tx_count,
    output logic                              o_tx_dropped,
    output logic [2:0]                        o_link_state,
    output logic                              o_frame_ended,
    output logic                              o_initiator,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [bhsl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bhsl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // Input register.
    logic r_in_valid;
    logic r_in_pin;
    logic r_in_push;
    logic r_in_bit;

    // Result register.
    logic                            r_out_valid;
    bhsl_pkg::t_link_res             r_out_res;
    logic [bhsl_pkg::COUNT_OUT_W-1:0] r_out_count;
    logic                            r_out_dropped;

    bhsl_pkg::t_cfg       r_cfg;
    bhsl_pkg::t_fifo_stat fifo_stat;
    bhsl_pkg::t_link_res  link_res;
    logic [bhsl_pkg::COUNT_OUT_W-1:0] fifo_count;
    logic                 fire;
    logic                 pull;
    logic                 in_take;

    // The held tick is processed whenever the result register can take it.
    assign fire       = r_in_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_in_valid & ~fire;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pin  <= i_pin_level;
            r_in_push <= i_tx_valid;
            r_in_bit  <= i_tx_bit;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.may_initiate  <= 1'b1;
            r_cfg.frame_timeout <= 16'd1000;
            r_cfg.read_delay    <= 16'd50;
            r_cfg.write_delay   <= 16'd50;
            r_cfg.pulse_ticks   <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bhsl_pkg::CFG_MAY_INITIATE:  r_cfg.may_initiate  <= i_cfg_wdata[0];
                bhsl_pkg::CFG_FRAME_TIMEOUT: r_cfg.frame_timeout <= i_cfg_wdata;
                bhsl_pkg::CFG_READ_DELAY:    r_cfg.read_delay    <= i_cfg_wdata;
                bhsl_pkg::CFG_WRITE_DELAY:   r_cfg.write_delay   <= i_cfg_wdata;
                bhsl_pkg::CFG_PULSE_TICKS: begin
                    r_cfg.pulse_ticks <= i_cfg_wdata[bhsl_pkg::PULSE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bhsl_tx_fifo #(
        .DEPTH (TX_DEPTH)
    ) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_push  (r_in_push),
        .i_bit   (r_in_bit),
        .i_pull  (pull),
        .o_stat  (fifo_stat),
        .o_count (fifo_count)
    );

    bhsl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cfg   (r_cfg),
        .i_pin   (r_in_pin),
        .i_fifo  (fifo_stat),
        .o_pull  (pull),
        .o_res   (link_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res     <= link_res;
            r_out_count   <= fifo_count;
            r_out_dropped <= fifo_stat.dropped;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_out    = r_out_res.line_out;
    assign o_rx_valid    = r_out_res.rx_valid;
    assign o_rx_bit      = r_out_res.rx_bit;
    assign o_tx_count    = r_out_count;
    assign o_tx_dropped  = r_out_dropped;
    assign o_link_state  = r_out_res.link_state;
    assign o_frame_ended = r_out_res.frame_ended;
    assign o_initiator   = r_out_res.initiator;

endmodule

// ===== hw/rtl/bhsl_tx_fifo.sv =====
// Transmit bit queue of the serial link: a shift-register FIFO whose head
// is always entry zero. Depends on bhsl_pkg.
module bhsl_tx_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic                             i_push,
    input  logic                             i_bit,
    input  logic                             i_pull,
    output bhsl_pkg::t_fifo_stat             o_stat,
    output logic [bhsl_pkg::COUNT_OUT_W-1:0] o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int unsigned COUNT_OUT_W = bhsl_pkg::COUNT_OUT_W;

    logic [DEPTH-1:0] r_q;
    logic [DEPTH-1:0] n_q;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [CW-1:0]    cnt_push;
    logic [CW-1:0]    widx;
    logic             full;
    logic             push_ok;
    logic             wr_en;

    assign full     = (r_cnt == CW'(DEPTH));
    assign push_ok  = i_push & ~full;
    assign cnt_push = r_cnt + CW'(push_ok);
    assign n_cnt    = cnt_push - CW'(i_pull);

    assign o_stat.has_data = push_ok | (r_cnt != '0);
    // An empty queue hands this tick's pushed bit straight to the head.
    assign o_stat.head_bit = (r_cnt == '0) ? i_bit : r_q[0];
    assign o_stat.dropped  = i_push & full;
    assign o_count         = COUNT_OUT_W'(32'(n_cnt));

    // The push lands after the shift, so it goes one place lower on a pull.
    assign widx  = i_pull ? (r_cnt - CW'(1)) : r_cnt;
    assign wr_en = push_ok & ~(i_pull & (r_cnt == '0));

    always_comb begin
        n_q = i_pull ? (r_q >> 1) : r_q;
        if (wr_en) begin
            n_q[widx[IW-1:0]] = i_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_q <= n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/bhsl_ctrl.sv =====
// Link controller of the serial link: edge detection, elapsed tick counter
// and the phase machine with its strobe pulse. Depends on bhsl_pkg.
module bhsl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bhsl_pkg::t_cfg       i_cfg,
    input  logic                 i_pin,
    input  bhsl_pkg::t_fifo_stat i_fifo,
    output logic                 o_pull,
    output bhsl_pkg::t_link_res  o_res
);

    localparam int unsigned TW = bhsl_pkg::TICK_W;
    localparam int unsigned PW = bhsl_pkg::PULSE_W;

    logic [2:0]    r_phase,      n_phase;
    logic [2:0]    r_after,      n_after;
    logic          r_pulse_bit,  n_pulse_bit;
    logic [PW-1:0] r_pulse_left, n_pulse_left;
    logic [TW-1:0] r_elapsed,    n_elapsed;
    logic          r_edge,       n_edge;
    logic          r_prev_pin;
    logic          r_frame_end,  n_frame_end;
    logic          r_started,    n_started;
    logic          r_drive,      n_drive;
    logic          rx_valid;
    logic          rx_bit;
    logic          pull;
    logic          pulse_go;
    logic          pulse_val;
    logic [2:0]    pulse_next;

    always_comb begin
        n_phase      = r_phase;
        n_after      = r_after;
        n_pulse_bit  = r_pulse_bit;
        n_pulse_left = r_pulse_left;
        n_elapsed    = (r_elapsed != '1) ? (r_elapsed + TW'(1)) : r_elapsed;
        n_edge       = r_edge | (i_pin & ~r_prev_pin);
        n_frame_end  = r_frame_end;
        n_started    = r_started;
        n_drive      = r_drive;
        rx_valid     = 1'b0;
        rx_bit       = 1'b0;
        pull         = 1'b0;
        pulse_go     = 1'b0;
        pulse_val    = 1'b0;
        pulse_next   = bhsl_pkg::PH_IDLE;

        case (r_phase)
            bhsl_pkg::PH_IDLE: begin
                if (n_edge) begin
                    n_started   = 1'b0;
                    n_frame_end = 1'b0;
                    n_phase     = bhsl_pkg::PH_READ;
                    n_elapsed   = '0;
                    n_edge      = 1'b0;
                end else if (r_frame_end) begin
                    if (i_cfg.may_initiate && i_fifo.has_data) begin
                        n_started   = 1'b1;
                        pull        = 1'b1;
                        pulse_go    = 1'b1;
                        pulse_val   = i_fifo.head_bit;
                        pulse_next  = bhsl_pkg::PH_WAIT;
                        n_frame_end = 1'b0;
                        n_elapsed   = '0;
                    end
                end else if (n_elapsed >= i_cfg.frame_timeout) begin
                    n_frame_end = 1'b1;
                end
            end
            bhsl_pkg::PH_READ: begin
                if (n_elapsed >= i_cfg.read_delay) begin
                    rx_valid = 1'b1;
                    rx_bit   = i_pin;
                    if (!i_fifo.has_data) begin
                        if (r_started) begin
                            n_drive   = 1'b0;
                            n_edge    = 1'b0;
                            n_started = 1'b0;
                            n_phase   = bhsl_pkg::PH_IDLE;
                        end else begin
                            // Nothing to send: strobe, then a low acknowledge.
                            pulse_go   = 1'b1;
                            pulse_val  = 1'b0;
                            pulse_next = bhsl_pkg::PH_IDLE;
                        end
                    end else begin
                        pull       = 1'b1;
                        pulse_go   = 1'b1;
                        pulse_val  = i_fifo.head_bit;
                        pulse_next = bhsl_pkg::PH_WAIT;
                    end
                    n_elapsed = '0;
                end
            end
            bhsl_pkg::PH_WAIT: begin
                if (n_edge) begin
                    n_phase   = bhsl_pkg::PH_WEND;
                    n_elapsed = '0;
                    n_edge    = 1'b0;
                end
            end
            bhsl_pkg::PH_WEND: begin
                if (n_elapsed >= i_cfg.write_delay) begin
                    n_drive   = 1'b0;
                    n_phase   = bhsl_pkg::PH_READ;
                    n_elapsed = '0;
                end
            end
            bhsl_pkg::PH_PULSE: begin
                if (r_pulse_left > PW'(1)) begin
                    n_pulse_left = r_pulse_left - PW'(1);
                end else begin
                    // A zero pulse length ends here as well, like a length of one.
                    n_pulse_left = '0;
                    n_drive      = r_pulse_bit;
                    n_phase      = r_after;
                end
            end
            default: begin
            end
        endcase

        if (pulse_go) begin
            n_drive      = 1'b1;
            n_pulse_bit  = pulse_val;
            n_after      = pulse_next;
            n_pulse_left = i_cfg.pulse_ticks;
            n_phase      = bhsl_pkg::PH_PULSE;
        end
    end

    assign o_pull = pull;

    assign o_res.line_out    = n_drive;
    assign o_res.rx_valid    = rx_valid;
    assign o_res.rx_bit      = rx_bit;
    assign o_res.link_state  = n_phase;
    assign o_res.frame_ended = n_frame_end;
    assign o_res.initiator   = n_started;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bhsl_pkg::PH_IDLE;
            r_after      <= bhsl_pkg::PH_IDLE;
            r_pulse_bit  <= 1'b0;
            r_pulse_left <= '0;
            r_elapsed    <= '0;
            r_edge       <= 1'b0;
            r_prev_pin   <= 1'b0;
            r_frame_end  <= 1'b0;
            r_started    <= 1'b0;
            r_drive      <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_after      <= n_after;
            r_pulse_bit  <= n_pulse_bit;
            r_pulse_left <= n_pulse_left;
            r_elapsed    <= n_elapsed;
            r_edge       <= n_edge;
            r_prev_pin   <= i_pin;
            r_frame_end  <= n_frame_end;
            r_started    <= n_started;
            r_drive      <= n_drive;
        end
    end

endmodule
